/* hw/rtl/ile_pkg.sv */
package ile_pkg;

   // field widths of the two channels
   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int TOTAL_W = 5;

   // default sizing
   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_DATA_WIDTH = 32;

   // command codes
   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_READ   = 3'd2,
      CMD_PUSH   = 3'd3,
      CMD_POP    = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]         command;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic [TOTAL_W-1:0] element_total;
      status_type         status;
   } rsp_type;

   // shift order broadcast to every cell
   typedef struct packed {
      logic shift_up;
      logic shift_down;
   } cell_ctrl_type;

endpackage

/* hw/rtl/ile_cell.sv */
module ile_cell
   import ile_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   parameter int CELL_INDEX = 0,
   localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [IDX_W-1:0]      position,
   input  logic [DATA_WIDTH-1:0] new_value,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic [DATA_WIDTH-1:0] data
);

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   // pick own entry, neighbor or new value
   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_up) begin
         if (MY_INDEX > position) begin
            data_in = left_data;
         end else if (MY_INDEX == position) begin
            data_in = new_value;
         end
      end else if (ctrl.shift_down) begin
         if (MY_INDEX >= position) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* hw/rtl/indexed_list_engine.sv */
// channel | ports                          | transfer when
// --------+--------------------------------+------------------------
// request | req_valid, req_ready, req_data | req_valid && req_ready
// result  | rsp_valid, rsp_ready, rsp_data | rsp_valid && rsp_ready
//
// The row of cells shifts, loads or holds in the cycle of the transfer,
// and the result sits in an output register the next cycle. A new command
// is taken each cycle while the result side keeps up. Synchronous reset
// empties the list; entry contents are not cleared. While a result waits
// on rsp_ready the request side stalls.
module indexed_list_engine
   import ile_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CMP_W-1:0] CAP_EXT = CMP_W'(CAPACITY);

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic                  req_xfer;
   logic [CMP_W-1:0]      cnt_ext;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      target;
   logic                  is_full;
   logic                  is_empty;
   cell_ctrl_type         ctrl;
   status_type            status;
   logic                  take_value;
   logic [DATA_WIDTH-1:0] new_value;
   logic [DATA_WIDTH-1:0] sel_data;
   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   assign cnt_ext   = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(req_data.position);
   assign is_full   = (cnt_ext == CAP_EXT);
   assign is_empty  = (count_ff == '0);
   assign new_value = DATA_WIDTH'(req_data.value);

   // command decode and range checks
   always_comb begin
      ctrl       = '0;
      status     = ST_OK;
      take_value = 1'b0;
      target     = pos_ext;
      count_in   = count_ff;
      case (req_data.command)
         CMD_INSERT, CMD_PUSH: begin
            if (req_data.command == CMD_PUSH) begin
               target = cnt_ext;
            end
            if (req_data.command == CMD_INSERT && pos_ext > cnt_ext) begin
               status = ST_RANGE;
            end else if (is_full) begin
               status = ST_FULL;
            end else begin
               ctrl.shift_up = 1'b1;
               count_in      = count_ff + 1'b1;
            end
         end
         CMD_REMOVE, CMD_READ, CMD_POP: begin
            if (req_data.command == CMD_POP) begin
               target = cnt_ext - 1'b1;
            end
            if (is_empty) begin
               status = ST_EMPTY;
            end else if (req_data.command != CMD_POP && pos_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               take_value = 1'b1;
               if (req_data.command != CMD_READ) begin
                  ctrl.shift_down = 1'b1;
                  count_in        = count_ff - 1'b1;
               end
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      if (!req_xfer) begin
         ctrl     = '0;
         count_in = count_ff;
      end
   end

   // row of storage cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end
      ile_cell #(
         .CAPACITY   (CAPACITY),
         .DATA_WIDTH (DATA_WIDTH),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .position   (target[IDX_W-1:0]),
         .new_value  (new_value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   assign sel_data = cell_data[target[IDX_W-1:0]];

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (req_xfer) begin
         rsp_valid_in         = 1'b1;
         rsp_in.read_value    = take_value ? VALUE_W'(sel_data) : '0;
         rsp_in.element_total = TOTAL_W'(count_in);
         rsp_in.status        = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CAP_EXT)
      else $error("element count above capacity");

   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      req_xfer && status != ST_OK |=> count_ff == $past(count_ff))
      else $error("failed command changed the count");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |-> rsp_ff.read_value == '0)
      else $error("error result carries data");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_data.command == CMD_CLEAR |=> count_ff == '0)
      else $error("clear left elements");
`endif

endmodule
